// ----- rtl/core/bta_pkg.sv -----
// Package for the bakery ticket arbiter: item types, opcodes, FSM states.
// No dependencies; used by bta_ram users and the top level.
package bta_pkg;

  localparam int CLIENTS_DEF     = 16;
  localparam int TICKET_BITS_DEF = 16;

  typedef enum logic {
    OP_TAKE    = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [3:0] client;
  } in_item_t;

  typedef struct packed {
    logic        grant_valid;
    logic [3:0]  granted_client;
    logic [15:0] issued_ticket;
    logic        overflow;
  } out_item_t;

endpackage

// ----- rtl/core/bta_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bta_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/bakery_ticket_arbiter.sv -----
// Bakery ticket arbiter top level: FSM, scan accumulators, ticket store.
// Depends on bta_pkg and bta_ram.
//
//  channel | ports                 | transfer when
//  --------+-----------------------+---------------------------
//  input   | start, busy, in_data  | start high, busy low
//  result  | out_valid, out_data   | out_valid high (one cycle)
//
// The ticket store is read one entry a cycle over its single read port in
// ST_SCAN; ST_DRAIN takes the last read data and ST_FIN settles the item and
// writes back. The result strobe follows in the cycle after ST_FIN, while the
// next item may already be taken. Reset clears the per-entry valid bits at
// once, so no clearing pass is needed. The receiver cannot stall.
module bakery_ticket_arbiter #(
  parameter int CLIENTS     = bta_pkg::CLIENTS_DEF,
  parameter int TICKET_BITS = bta_pkg::TICKET_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bta_pkg::in_item_t in_data,
  output logic              out_valid,
  output bta_pkg::out_item_t out_data
);

  import bta_pkg::*;

  localparam int CW = $clog2(CLIENTS);
  localparam int TB = TICKET_BITS;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     idx_r;
  logic              rd_vld_r;
  logic [CLIENTS-1:0] vld_r;

  opcode_t           op_r;
  logic [CW-1:0]     who_r;
  logic              in_range_r;

  logic [TB-1:0]     max_r;
  logic [TB-1:0]     best_r;
  logic [CW-1:0]     best_idx_r;
  logic              have_r;
  logic [TB-1:0]     own_r;

  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              accept;
  logic              ram_we;
  logic [CW-1:0]     ram_raddr;
  logic [TB-1:0]     ram_rdata;
  logic [TB-1:0]     rd_t;
  logic [8:0]        client_ext;

  logic              top_hit;
  logic              take_ok;
  logic              ovf;
  logic [TB-1:0]     own_new;
  logic              own_wins;
  logic [CW-1:0]     g_idx;
  logic [8:0]        g_ext;
  logic [31:0]       own_ext;

  assign accept     = start && !busy;
  assign client_ext = {5'd0, in_data.client};
  assign rd_t       = vld_r[idx_r] ? ram_rdata : '0;

  // FSM next state and control
  always_comb begin
    state_nxt = state_r;
    busy      = 1'b1;
    ram_raddr = cnt_r;
    ram_we    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r == CW'(CLIENTS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        ram_we    = in_range_r && !ovf;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Read address walk and registered tag of the data in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == ST_SCAN);
      if (accept) begin
        cnt_r <= '0;
      end else if (state_r == ST_SCAN) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= cnt_r;
  end

  // Settle the item from the scan results
  always_comb begin
    top_hit  = &max_r;
    take_ok  = (op_r == OP_TAKE) && !top_hit;
    ovf      = in_range_r && (op_r == OP_TAKE) && top_hit;
    if (op_r == OP_RELEASE) begin
      own_new = '0;
    end else if (top_hit) begin
      own_new = own_r;
    end else begin
      own_new = max_r + TB'(1);
    end
    // new ticket is above all others; only ties with an unchanged own ticket matter
    own_wins = in_range_r && (own_new != '0) &&
               (!have_r || (own_new < best_r) ||
                ((own_new == best_r) && (who_r < best_idx_r)));
    g_idx    = own_wins ? who_r : best_idx_r;
    g_ext    = 9'(g_idx);
    own_ext  = 32'(own_new);
  end

  // Scan accumulators; the client's own slot is kept apart from the rest
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_data.opcode;
      who_r      <= client_ext[CW-1:0];
      in_range_r <= (32'(client_ext) < 32'(CLIENTS));
      max_r      <= '0;
      best_r     <= '0;
      best_idx_r <= '0;
      have_r     <= 1'b0;
      own_r      <= '0;
    end else if (rd_vld_r) begin
      if (rd_t > max_r) begin
        max_r <= rd_t;
      end
      if (in_range_r && (idx_r == who_r)) begin
        own_r <= rd_t;
      end else if ((rd_t != '0) && (!have_r || (rd_t < best_r))) begin
        have_r     <= 1'b1;
        best_r     <= rd_t;
        best_idx_r <= idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ram_we) begin
      vld_r[who_r] <= 1'b1;
    end
  end

  bta_ram #(
    .WIDTH (TB),
    .DEPTH (CLIENTS)
  ) u_ticket_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (who_r),
    .wdata (own_new),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result register: strobe for one cycle after the write-back cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN) begin
      out_data_r.grant_valid    <= have_r || own_wins;
      out_data_r.granted_client <= (have_r || own_wins) ? g_ext[3:0] : 4'd0;
      out_data_r.issued_ticket  <= (in_range_r && take_ok) ? own_ext[15:0] : 16'd0;
      out_data_r.overflow       <= ovf;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not raise busy");

  a_we_fin : assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_FIN))
    else $error("ticket store written outside write-back");

  a_strobe_src : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_FIN))
    else $error("result strobe without a finished item");

  a_ovf_no_ticket : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.overflow) |-> (out_data.issued_ticket == 16'd0))
    else $error("ticket issued on overflow");

  a_idle_grant : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.grant_valid) |-> (out_data.granted_client == 4'd0))
    else $error("granted client set with no holder");
`endif

endmodule
